### sv/character_lcd_bus_sequencer_assert.svh
// Assertion macros used by the sequencer's checker file.
`ifndef CHARACTER_LCD_BUS_SEQUENCER_ASSERT_SVH
`define CHARACTER_LCD_BUS_SEQUENCER_ASSERT_SVH

// Property checked while out of reset.
`define LCDSEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked at every edge, reset included.
`define LCDSEQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lcdseq_pkg.sv
// Package: operation codes, transfer descriptors and the transfer table of the sequencer.
package lcdseq_pkg;

  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_WRITE_CMD  = 3'd1,
    OP_WRITE_DATA = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_SET_CURSOR = 3'd4
  } op_t;

  localparam int STEP_W          = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0]  CMD_FUNC_8BIT   = 8'h38;
  localparam logic [7:0]  CMD_FUNC_4BIT   = 8'h28;
  localparam logic [7:0]  CMD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0]  CMD_CLEAR       = 8'h01;
  localparam logic [7:0]  CMD_DDRAM_ROW0  = 8'h80;
  localparam logic [7:0]  CMD_DDRAM_ROW1  = 8'hC0;
  localparam logic [3:0]  NIB_RESET       = 4'h3;
  localparam logic [3:0]  NIB_4BIT        = 4'h2;
  localparam logic [15:0] POWERUP_US      = 16'd40000;
  localparam logic [12:0] CMD_US          = 13'd50;
  localparam logic [12:0] CLEAR_US        = 13'd2050;
  localparam logic [12:0] RESET1_US       = 13'd5000;
  localparam logic [12:0] RESET2_US       = 13'd150;

  // One classified operation waiting for the back end.
  typedef struct packed {
    logic       is_init;
    logic       nibble_mode;
    logic       rs;
    logic [7:0] data;
    logic       long_wait;
  } desc_t;

  // One bus transfer.
  typedef struct packed {
    logic        rs;
    logic [7:0]  bus_value;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
    logic        last;
  } xfer_t;

  // Transfer number 'step' of the run that descriptor 'd' expands into.
  function automatic xfer_t xfer_at(desc_t d, logic [STEP_W-1:0] step);
    xfer_t             x;
    logic [STEP_W-1:0] bstep;
    logic [1:0]        bidx;
    logic [7:0]        byte_v;
    logic              last_byte;
    logic              long_v;
    logic              end_of_byte;
    x = '0;
    if (d.is_init && d.nibble_mode && (step < STEP_W'(4))) begin
      // raw reset nibbles of the 4-bit wake-up
      x.rs        = 1'b0;
      x.bus_value = {4'h0, (step == STEP_W'(3)) ? NIB_4BIT : NIB_RESET};
      x.wait_before = (step == '0) ? POWERUP_US : 16'd0;
      if (step == '0) begin
        x.wait_after = RESET1_US;
      end else if (step == STEP_W'(1)) begin
        x.wait_after = RESET2_US;
      end else begin
        x.wait_after = 13'd0;
      end
      x.last = 1'b0;
    end else begin
      bstep = (d.is_init && d.nibble_mode) ? step - STEP_W'(4) : step;
      bidx  = d.nibble_mode ? bstep[2:1] : bstep[1:0];
      if (!d.is_init) begin
        byte_v = d.data;
      end else begin
        case (bidx)
          2'd0:    byte_v = d.nibble_mode ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
          2'd1:    byte_v = CMD_DISPLAY_ON;
          2'd2:    byte_v = CMD_ENTRY_MODE;
          default: byte_v = CMD_CLEAR;
        endcase
      end
      last_byte   = !d.is_init || (bidx == 2'd3);
      long_v      = d.is_init ? (bidx == 2'd3) : d.long_wait;
      end_of_byte = !d.nibble_mode || bstep[0];
      x.rs = d.rs;
      if (!d.nibble_mode) begin
        x.bus_value = byte_v;
      end else if (bstep[0]) begin
        x.bus_value = {4'h0, byte_v[3:0]};
      end else begin
        x.bus_value = {4'h0, byte_v[7:4]};
      end
      x.wait_before = (d.is_init && !d.nibble_mode && (step == '0)) ? POWERUP_US : 16'd0;
      x.wait_after  = end_of_byte ? (long_v ? CLEAR_US : CMD_US) : 13'd0;
      x.last        = last_byte && end_of_byte;
    end
    return x;
  endfunction

endpackage

### sv/lcdseq_if.sv
// Channel interfaces of the sequencer: operation input, transfer output, configuration write.
interface lcdseq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] value;
  logic [3:0] column;
  logic       row;
  modport source (output valid, output operation, output value, output column,
                  output row, input ready);
  modport sink   (input valid, input operation, input value, input column,
                  input row, output ready);
endinterface

interface lcdseq_out_if;
  logic        valid;
  logic        ready;
  logic        register_select;
  logic [7:0]  bus_value;
  logic [15:0] wait_before_us;
  logic [12:0] wait_after_us;
  logic        last;
  modport source (output valid, output register_select, output bus_value,
                  output wait_before_us, output wait_after_us, output last,
                  input ready);
  modport sink   (input valid, input register_select, input bus_value,
                  input wait_before_us, input wait_after_us, input last,
                  output ready);
endinterface

interface lcdseq_cfg_if;
  logic valid;
  logic ready;
  logic bus_mode;
  modport source (output valid, output bus_mode, input ready);
  modport sink   (input valid, input bus_mode, output ready);
endinterface

### sv/lcdseq_front.sv
// Front end: accept operations, classify them into descriptors, drop unknown codes.
module lcdseq_front
  import lcdseq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  lcdseq_in_if.sink    in_ch,
  input  logic         bus_mode,
  output logic         push_valid,
  input  logic         push_ready,
  output desc_t        push_desc
);

  logic  v_r, v_nxt;
  desc_t d_r, d_nxt;
  logic  accept;
  logic  known;
  desc_t cls;

  assign in_ch.ready = !v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cls             = '0;
    cls.nibble_mode = bus_mode;
    known           = 1'b1;
    case (op_t'(in_ch.operation))
      OP_INIT:       cls.is_init = 1'b1;
      OP_WRITE_CMD:  cls.data = in_ch.value;
      OP_WRITE_DATA: begin
        cls.rs   = 1'b1;
        cls.data = in_ch.value;
      end
      OP_CLEAR: begin
        cls.data      = CMD_CLEAR;
        cls.long_wait = 1'b1;
      end
      OP_SET_CURSOR: begin
        cls.data = (in_ch.row ? CMD_DDRAM_ROW1 : CMD_DDRAM_ROW0) | {4'h0, in_ch.column};
      end
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    if (accept && known) begin
      v_nxt = 1'b1;
      d_nxt = cls;
    end else if (push_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    d_r <= d_nxt;
  end

  assign push_valid = v_r;
  assign push_desc  = d_r;

endmodule

### sv/lcdseq_queue.sv
// Descriptor queue between the front end and the back end.
module lcdseq_queue
  import lcdseq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  desc_t push_desc,
  output logic  q_valid,
  input  logic  q_pop,
  output desc_t q_desc
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign q_valid    = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = q_pop && q_valid;
  assign q_desc     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### sv/lcdseq_back.sv
// Back end: step through the head descriptor's run, one transfer per unstalled cycle.
module lcdseq_back
  import lcdseq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  desc_t         q_desc,
  output logic          q_pop,
  lcdseq_out_if.source  out_ch
);

  logic              out_v_r, out_v_nxt;
  xfer_t             out_x_r, out_x_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  xfer_t             x;
  logic              load;

  assign x     = xfer_at(q_desc, step_r);
  assign load  = q_valid && (!out_v_r || out_ch.ready);
  assign q_pop = load && x.last;

  always_comb begin
    out_v_nxt = out_v_r;
    out_x_nxt = out_x_r;
    step_nxt  = step_r;
    if (load) begin
      out_v_nxt = 1'b1;
      out_x_nxt = x;
      step_nxt  = x.last ? '0 : step_r + STEP_W'(1);
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      step_r  <= '0;
    end else begin
      out_v_r <= out_v_nxt;
      step_r  <= step_nxt;
    end
    out_x_r <= out_x_nxt;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.register_select = out_x_r.rs;
  assign out_ch.bus_value       = out_x_r.bus_value;
  assign out_ch.wait_before_us  = out_x_r.wait_before;
  assign out_ch.wait_after_us   = out_x_r.wait_after;
  assign out_ch.last            = out_x_r.last;

endmodule

### sv/character_lcd_bus_sequencer.sv
// Top level of the character display bus sequencer.
//
// Turns display operations (power-up init, write command, write data, clear,
// set cursor) into the run of enable-strobed bus transfers an HD44780-style
// controller expects; each output transfer carries register select, the bus
// value (full byte in 8-bit mode, high then low nibble in the low bits in
// 4-bit mode), the wait before and the wait after the strobe in microseconds,
// and a last flag on the final transfer of the run. Actual pin timing,
// including the implied 2 us high / 2 us low enable pulse, is done downstream.
// Rate: the back end emits one transfer per clock while the output is not
// stalled; an operation expands into 1 (8-bit byte), 2 (4-bit byte), 4 (8-bit
// init) or 12 (4-bit init) transfers. The front end takes one operation per
// clock while the descriptor queue (QUEUE_DEPTH entries) has room, so
// operations arrive back to back; the first transfer of an operation passes
// the front-end register, the descriptor queue and the back-end output
// register before it appears. Operation codes 5 to 7 are taken and dropped
// with no output. bus_mode is sampled when an operation is accepted; write
// it only while the block is idle. The configuration port is always ready.
module character_lcd_bus_sequencer
  import lcdseq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  lcdseq_in_if.sink    in_ch,
  lcdseq_out_if.source out_ch,
  lcdseq_cfg_if.sink   cfg_ch
);

  logic  bus_mode_r, bus_mode_nxt;
  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  q_valid;
  logic  q_pop;
  desc_t q_desc;

  // Config register: take every write transfer.
  assign cfg_ch.ready = 1'b1;
  assign bus_mode_nxt = cfg_ch.valid ? cfg_ch.bus_mode : bus_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_mode_r <= 1'b0;
    end else begin
      bus_mode_r <= bus_mode_nxt;
    end
  end

  // Classify operations; hold one descriptor until the queue takes it.
  lcdseq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .bus_mode   (bus_mode_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  // Decouple the front end from the back end so each stalls on its own.
  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_desc     (q_desc)
  );

  // Expand the head descriptor into transfers; pop it on its last transfer.
  lcdseq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### sv/lcdseq_checker.sv
// Port-level checker for the sequencer, bound to the top level.
`include "character_lcd_bus_sequencer_assert.svh"

module lcdseq_checker
  import lcdseq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_register_select,
  input logic [7:0]  out_bus_value,
  input logic [15:0] out_wait_before_us,
  input logic [12:0] out_wait_after_us,
  input logic        out_last
);

  `LCDSEQ_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_valid, "output valid right after reset")

  `LCDSEQ_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_bus_value) && $stable(out_last) && $stable(out_wait_after_us), "stalled transfer changed")

  `LCDSEQ_ASSERT(a_powerup_wait, out_valid && (out_wait_before_us != 16'd0) |-> (out_wait_before_us == POWERUP_US) && !out_register_select && !out_last, "wait before outside power-up transfer")

  `LCDSEQ_ASSERT(a_last_waits, out_valid && out_last |-> (out_wait_after_us == CMD_US) || (out_wait_after_us == CLEAR_US), "final transfer without settle wait")

endmodule

bind character_lcd_bus_sequencer lcdseq_checker u_lcdseq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_register_select (out_ch.register_select),
  .out_bus_value       (out_ch.bus_value),
  .out_wait_before_us  (out_ch.wait_before_us),
  .out_wait_after_us   (out_ch.wait_after_us),
  .out_last            (out_ch.last)
);

### sim/tb.sv
// Self-checking testbench for the character display bus sequencer: directed and random operations, scoreboarded transfers.
`timescale 1ns / 1ps

module tb;
  import lcdseq_pkg::*;

  // Display protocol bytes, nibbles and waits as the predictor sees them.
  localparam logic [7:0]  BYTE_FUNC_8     = 8'h38;
  localparam logic [7:0]  BYTE_FUNC_4     = 8'h28;
  localparam logic [7:0]  BYTE_DISP_ON    = 8'h0C;
  localparam logic [7:0]  BYTE_ENTRY      = 8'h06;
  localparam logic [7:0]  BYTE_CLEAR      = 8'h01;
  localparam logic [7:0]  BYTE_ROW0       = 8'h80;
  localparam logic [7:0]  BYTE_ROW1       = 8'hC0;
  localparam logic [7:0]  NIBBLE_WAKE     = 8'h03;
  localparam logic [7:0]  NIBBLE_GO4      = 8'h02;
  localparam logic [15:0] WAIT_POWERUP    = 16'd40000;
  localparam logic [12:0] WAIT_BYTE       = 13'd50;
  localparam logic [12:0] WAIT_CLEAR      = 13'd2050;
  localparam logic [12:0] WAIT_WAKE_FIRST = 13'd5000;
  localparam logic [12:0] WAIT_WAKE_NEXT  = 13'd150;

  // Run shape.
  localparam int RANDOM_OPS     = 170;
  localparam int PHASES         = 6;
  localparam int SETTLE_CYCLES  = 16;   // covers the pipeline registers and a dropped op in flight
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Expected transfer runs, one per accepted operation with a known code, checked in order.
  class xfer_scoreboard;
    xfer_t expected_q[$];
    xfer_t run_q[$];
    logic  nibble_bus;
    int    errors;
    int    checked;
    int    ops_8bit;
    int    ops_4bit;
    int    ops_dropped;

    function new();
      nibble_bus  = 1'b0;
      errors      = 0;
      checked     = 0;
      ops_8bit    = 0;
      ops_4bit    = 0;
      ops_dropped = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function void add_xfer(logic rs, logic [7:0] val, logic [15:0] pre, logic [12:0] post);
      xfer_t x;
      x.rs          = rs;
      x.bus_value   = val;
      x.wait_before = pre;
      x.wait_after  = post;
      x.last        = 1'b0;
      run_q.push_back(x);
    endfunction

    // Split a byte into high and low nibble on the narrow bus; no wait between them.
    function void add_byte(logic rs, logic [7:0] b, logic [15:0] pre, logic [12:0] post);
      if (!nibble_bus) begin
        add_xfer(rs, b, pre, post);
      end else begin
        add_xfer(rs, {4'h0, b[7:4]}, pre, 13'd0);
        add_xfer(rs, {4'h0, b[3:0]}, 16'd0, post);
      end
    endfunction

    function void note_operation(logic [2:0] op, logic [7:0] value, logic [3:0] column,
                                 logic row);
      xfer_t tail;
      run_q.delete();
      case (op)
        OP_INIT: begin
          if (!nibble_bus) begin
            add_byte(1'b0, BYTE_FUNC_8, WAIT_POWERUP, WAIT_BYTE);
          end else begin
            // wake-up nibbles before the controller knows it is on a 4-bit bus
            add_xfer(1'b0, NIBBLE_WAKE, WAIT_POWERUP, WAIT_WAKE_FIRST);
            add_xfer(1'b0, NIBBLE_WAKE, 16'd0, WAIT_WAKE_NEXT);
            add_xfer(1'b0, NIBBLE_WAKE, 16'd0, 13'd0);
            add_xfer(1'b0, NIBBLE_GO4, 16'd0, 13'd0);
            add_byte(1'b0, BYTE_FUNC_4, 16'd0, WAIT_BYTE);
          end
          add_byte(1'b0, BYTE_DISP_ON, 16'd0, WAIT_BYTE);
          add_byte(1'b0, BYTE_ENTRY, 16'd0, WAIT_BYTE);
          add_byte(1'b0, BYTE_CLEAR, 16'd0, WAIT_CLEAR);
        end
        OP_WRITE_CMD:  add_byte(1'b0, value, 16'd0, WAIT_BYTE);
        OP_WRITE_DATA: add_byte(1'b1, value, 16'd0, WAIT_BYTE);
        OP_CLEAR:      add_byte(1'b0, BYTE_CLEAR, 16'd0, WAIT_CLEAR);
        OP_SET_CURSOR: add_byte(1'b0, (row ? BYTE_ROW1 : BYTE_ROW0) + {4'h0, column}, 16'd0,
                                WAIT_BYTE);
        default: ;
      endcase
      if (run_q.size() == 0) begin
        ops_dropped++;
      end else begin
        tail      = run_q.pop_back();
        tail.last = 1'b1;
        run_q.push_back(tail);
        if (nibble_bus) ops_4bit++;
        else            ops_8bit++;
      end
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    task check_transfer(xfer_t got);
      xfer_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transfer rs=%0d bus=%02h last=%0d",
                         got.rs, got.bus_value, got.last));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.rs !== want.rs)
        report($sformatf("transfer %0d register_select %0d, want %0d",
                         checked, got.rs, want.rs));
      if (got.bus_value !== want.bus_value)
        report($sformatf("transfer %0d bus_value %02h, want %02h",
                         checked, got.bus_value, want.bus_value));
      if (got.wait_before !== want.wait_before)
        report($sformatf("transfer %0d wait_before_us %0d, want %0d",
                         checked, got.wait_before, want.wait_before));
      if (got.wait_after !== want.wait_after)
        report($sformatf("transfer %0d wait_after_us %0d, want %0d",
                         checked, got.wait_after, want.wait_after));
      if (got.last !== want.last)
        report($sformatf("transfer %0d last %0d, want %0d",
                         checked, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lcdseq_in_if  in_ch();
  lcdseq_out_if out_ch();
  lcdseq_cfg_if cfg_ch();

  character_lcd_bus_sequencer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  xfer_scoreboard sb = new();

  // Idle percentages per side; the main process changes them per phase.
  int tx_idle_pct;
  int rx_stall_pct;
  bit rx_hold_req;
  int valid_ops;
  int cfg_writes;
  int idle_cycles;

  always #10 clk = ~clk;

  // Pick a gap: none unless a pct-percent draw hits, mostly short when there is one, now and then long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Offer one operation; keep valid high from the previous transfer when no gap is drawn.
  task send_op(logic [2:0] op, logic [7:0] value, logic [3:0] column, logic row);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= value;
    in_ch.column    <= column;
    in_ch.row       <= row;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operation(op, value, column, row);
    if (op <= OP_SET_CURSOR) valid_ops++;
  endtask

  // Drop valid and hold until every expected transfer has arrived.
  task drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Write the bus width only with the block idle: drained and settled.
  task write_bus_mode(logic mode);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.bus_mode <= mode;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.nibble_bus = mode;
    cfg_writes++;
  endtask

  // Mostly well-formed display traffic, a few inits and some unused codes.
  task send_random_op();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(99);
    if (pick < 8)       op = OP_INIT;
    else if (pick < 33) op = OP_WRITE_CMD;
    else if (pick < 63) op = OP_WRITE_DATA;
    else if (pick < 73) op = OP_CLEAR;
    else if (pick < 94) op = OP_SET_CURSOR;
    else                op = 3'($urandom_range(7, 5));
    send_op(op, 8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  // Cover every operation at both bus widths, field extremes and the unused codes.
  task run_directed();
    write_bus_mode(1'b0);
    send_op(OP_INIT, 8'h00, 4'h0, 1'b0);
    send_op(OP_WRITE_CMD, 8'h00, 4'hF, 1'b1);
    send_op(OP_WRITE_CMD, 8'hFF, 4'h0, 1'b0);
    send_op(OP_WRITE_DATA, 8'h00, 4'h0, 1'b0);
    send_op(OP_WRITE_DATA, 8'hFF, 4'hF, 1'b1);
    send_op(OP_CLEAR, 8'hA5, 4'h5, 1'b1);
    send_op(OP_SET_CURSOR, 8'hFF, 4'h0, 1'b0);
    send_op(OP_SET_CURSOR, 8'h00, 4'hF, 1'b1);
    send_op(3'd5, 8'hFF, 4'hF, 1'b1);
    send_op(3'd6, 8'h00, 4'h0, 1'b0);
    send_op(3'd7, 8'h5A, 4'hA, 1'b1);
    write_bus_mode(1'b1);
    send_op(OP_INIT, 8'hFF, 4'hF, 1'b1);
    send_op(OP_WRITE_CMD, 8'hA5, 4'h3, 1'b0);
    send_op(OP_WRITE_DATA, 8'hFF, 4'h0, 1'b1);
    send_op(OP_WRITE_DATA, 8'h00, 4'hF, 1'b0);
    send_op(OP_CLEAR, 8'h00, 4'h0, 1'b0);
    send_op(OP_SET_CURSOR, 8'h3C, 4'hF, 1'b0);
    send_op(OP_SET_CURSOR, 8'hC3, 4'h0, 1'b1);
    send_op(3'd7, 8'h00, 4'h0, 1'b0);
    send_op(OP_INIT, 8'h00, 4'h0, 1'b0);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        // hold off long enough for the descriptor queue to fill and stall the input
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap(100)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check every transfer on the output channel against the oldest expectation.
  always @(posedge clk) begin : monitor
    xfer_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rs          = out_ch.register_select;
      got.bus_value   = out_ch.bus_value;
      got.wait_before = out_ch.wait_before_us;
      got.wait_after  = out_ch.wait_after_us;
      got.last        = out_ch.last;
      sb.check_transfer(got);
    end
  end

  // Watchdog: end the run when no channel moves anything for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d transfers still expected",
               $time, idle_cycles, sb.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int phase;
    int goal;
    int step;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_INIT;
    in_ch.value     <= 8'h00;
    in_ch.column    <= 4'h0;
    in_ch.row       <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.bus_mode <= 1'b0;
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    rx_hold_req  = 1'b0;
    valid_ops    = 0;
    cfg_writes   = 0;

    // Hold reset, then release it once for the whole run.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Random phases: each picks a bus width and its own idle pattern on both sides.
    valid_ops = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin write_bus_mode(1'b0); tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin write_bus_mode(1'b1); tx_idle_pct = 40; rx_stall_pct = 15; end
        2:       begin write_bus_mode(1'b1); tx_idle_pct = 0;  rx_stall_pct = 0;  end
        3:       begin write_bus_mode(1'b0); tx_idle_pct = 15; rx_stall_pct = 60; end
        default: begin
          write_bus_mode(1'($urandom));
          tx_idle_pct  = $urandom_range(70);
          rx_stall_pct = $urandom_range(70);
        end
      endcase
      goal = (RANDOM_OPS * (phase + 1)) / PHASES;
      step = 0;
      while (valid_ops < goal) begin
        // keep offering operations while the receiver is held off
        if (phase == 2 && step == 3) rx_hold_req = 1'b1;
        // pause the sender mid-phase until everything has come out
        if (phase == 3 && step == 12) drain_results();
        send_random_op();
        step++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d operations on the 8-bit bus, %0d on the 4-bit bus, %0d unused codes",
             sb.ops_8bit, sb.ops_4bit, sb.ops_dropped);
    $display("Checked %0d transfers over %0d bus width writes, with a %0d-cycle output hold-off",
             sb.checked, cfg_writes, RX_HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### character_lcd_bus_sequencer.f
+incdir+sv
sv/lcdseq_pkg.sv
sv/lcdseq_if.sv
sv/lcdseq_front.sv
sv/lcdseq_queue.sv
sv/lcdseq_back.sv
sv/character_lcd_bus_sequencer.sv
sv/lcdseq_checker.sv
sim/tb.sv
